@@ rtl/saso_pkg.sv @@
// ============================================================================
// saso_pkg: shared definitions for the sorted assignment set unit
// Sizes, key layout, action/operation/status codes and the transfer structs.
// ============================================================================
package saso_pkg;

    // Sizes of the lists and of one stored assignment.
    localparam int DEPTH       = 64;
    localparam int NODE_BITS   = 20;
    localparam int KEY_BITS    = NODE_BITS + 1;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int INDEX_BITS  = 6;

    // Action codes carried by an input transfer.
    typedef enum logic [2:0] {
        ACT_CLEAR    = 3'd0,
        ACT_APPEND_A = 3'd1,
        ACT_APPEND_B = 3'd2,
        ACT_RUN      = 3'd3,
        ACT_READ     = 3'd4
    } action_t;

    // Operation codes for a run.
    typedef enum logic [2:0] {
        OP_UNION    = 3'd0,
        OP_DIFF     = 3'd1,
        OP_CONFLICT = 3'd2,
        OP_CONTAIN  = 3'd3,
        OP_SANITY   = 3'd4
    } op_t;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // One input item.
    typedef struct packed {
        logic [2:0]            action;
        logic [NODE_BITS-1:0]  node_id;
        logic                  assigned_value;
        logic [2:0]            operation;
        logic [INDEX_BITS-1:0] read_index;
    } req_t;

    // One result item.
    typedef struct packed {
        logic                 verdict;
        logic [1:0]           status;
        logic [CNT_BITS-1:0]  count_a;
        logic [NODE_BITS-1:0] read_node;
        logic                 read_value;
    } rsp_t;

endpackage

@@ rtl/saso_ram.sv @@
// ============================================================================
// saso_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module saso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/sorted_assignment_set_ops_unit.sv @@
// ============================================================================
// sorted_assignment_set_ops_unit: merge, difference and checks on two lists
// Keeps two ascending lists of (node, value) keys and walks them in step.
// ============================================================================
// Timing: a clear or an append gives its result in the cycle after the input
// transfer; a read of list A goes through S_READ_OUT. A run walks both lists
// with one shared key comparator; each walk step is S_STEP_RD (RAM read), then
// S_STEP_EV (compare), and there are at most count_a + count_b + 1 steps
// (count_a + 1 for sanity), the last one finding the walk finished. Union and
// difference then copy the scratch list back into list A, with S_COPY_RD and
// S_COPY_WR for each kept entry and a final S_COPY_RD. The input is stalled
// while a run or a read is in progress and while an unconsumed result blocks
// the output.
module sorted_assignment_set_ops_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  saso_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output saso_pkg::rsp_t  rsp
);

    localparam int KB = saso_pkg::KEY_BITS;
    localparam int AB = saso_pkg::ADDR_BITS;
    localparam int CB = saso_pkg::CNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_OUT,
        S_STEP_RD,
        S_STEP_EV,
        S_COPY_RD,
        S_COPY_WR
    } state_t;

    state_t          state_reg, state_next;
    logic [CB-1:0]   i_reg, i_next;
    logic [CB-1:0]   j_reg, j_next;
    logic [CB-1:0]   n_reg, n_next;
    logic [CB-1:0]   count_a_reg, count_a_next;
    logic [CB-1:0]   count_b_reg, count_b_next;
    logic [2:0]      op_reg, op_next;
    logic [KB-1:0]   prev_reg, prev_next;
    logic            over_reg, over_next;
    logic            rsp_valid_reg, rsp_valid_next;
    saso_pkg::rsp_t  rsp_reg, rsp_next;

    // RAM ports.
    logic            a_we, b_we, s_we;
    logic [AB-1:0]   a_waddr, b_waddr, s_waddr;
    logic [KB-1:0]   a_wdata, b_wdata, s_wdata;
    logic [AB-1:0]   a_raddr, b_raddr, s_raddr;
    logic [KB-1:0]   a_rdata, b_rdata, s_rdata;

    // Shared comparator and walk control.
    logic [KB-1:0]   cmp_lhs, cmp_rhs, merge_key;
    logic            key_lt, key_eq, node_eq;
    logic            a_more, b_more;
    logic            chk_done, chk_verdict, walk_done;

    saso_ram #(.WIDTH(KB), .DEPTH(saso_pkg::DEPTH)) u_list_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    saso_ram #(.WIDTH(KB), .DEPTH(saso_pkg::DEPTH)) u_list_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    saso_ram #(.WIDTH(KB), .DEPTH(saso_pkg::DEPTH)) u_scratch (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // The comparator sees A against B, or the previous A entry against the
    // current one during the sanity walk.
    always_comb
    begin
        if (op_reg == saso_pkg::OP_SANITY)
        begin
            cmp_lhs = prev_reg;
            cmp_rhs = a_rdata;
        end
        else
        begin
            cmp_lhs = a_rdata;
            cmp_rhs = b_rdata;
        end
        key_lt  = cmp_lhs < cmp_rhs;
        key_eq  = cmp_lhs == cmp_rhs;
        node_eq = cmp_lhs[KB-1:1] == cmp_rhs[KB-1:1];
        a_more  = i_reg < count_a_reg;
        b_more  = j_reg < count_b_reg;
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        op_next        = op_reg;
        prev_next      = prev_reg;
        over_next      = over_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        a_we      = 1'b0;
        a_waddr   = i_reg[AB-1:0];
        a_wdata   = s_rdata;
        a_raddr   = i_reg[AB-1:0];
        b_we      = 1'b0;
        b_waddr   = count_b_reg[AB-1:0];
        b_wdata   = {req.node_id, req.assigned_value};
        b_raddr   = j_reg[AB-1:0];
        s_we      = 1'b0;
        s_waddr   = n_reg[AB-1:0];
        s_wdata   = a_rdata;
        s_raddr   = i_reg[AB-1:0];
        merge_key = a_rdata;

        chk_done    = 1'b0;
        chk_verdict = 1'b0;
        walk_done   = 1'b0;

        req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);

        case (state_reg)
            S_IDLE:
            begin
                a_raddr = AB'(req.read_index);
                if (req_valid && !req_stall)
                begin
                    rsp_next         = '0;
                    rsp_next.count_a = count_a_reg;
                    case (req.action)
                        saso_pkg::ACT_CLEAR:
                        begin
                            count_a_next     = '0;
                            rsp_next.count_a = '0;
                            rsp_valid_next   = 1'b1;
                        end
                        saso_pkg::ACT_APPEND_A:
                        begin
                            if (count_a_reg < CB'(saso_pkg::DEPTH))
                            begin
                                a_we             = 1'b1;
                                a_waddr          = count_a_reg[AB-1:0];
                                a_wdata          = {req.node_id, req.assigned_value};
                                count_a_next     = count_a_reg + CB'(1);
                                rsp_next.count_a = count_a_reg + CB'(1);
                            end
                            else
                            begin
                                rsp_next.status = saso_pkg::ST_FULL;
                            end
                            rsp_valid_next = 1'b1;
                        end
                        saso_pkg::ACT_APPEND_B:
                        begin
                            if (count_b_reg < CB'(saso_pkg::DEPTH))
                            begin
                                b_we         = 1'b1;
                                count_b_next = count_b_reg + CB'(1);
                            end
                            else
                            begin
                                rsp_next.status = saso_pkg::ST_FULL;
                            end
                            rsp_valid_next = 1'b1;
                        end
                        saso_pkg::ACT_RUN:
                        begin
                            i_next    = '0;
                            j_next    = '0;
                            n_next    = '0;
                            over_next = 1'b0;
                            op_next   = req.operation;
                            if (req.operation <= saso_pkg::OP_SANITY)
                            begin
                                state_next = S_STEP_RD;
                            end
                            else
                            begin
                                // An unknown operation only empties list B.
                                count_b_next   = '0;
                                rsp_valid_next = 1'b1;
                            end
                        end
                        saso_pkg::ACT_READ:
                        begin
                            if (CB'(req.read_index) < count_a_reg)
                            begin
                                state_next = S_READ_OUT;
                            end
                            else
                            begin
                                rsp_next.status = saso_pkg::ST_RANGE;
                                rsp_valid_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_READ_OUT:
            begin
                rsp_next            = '0;
                rsp_next.count_a    = count_a_reg;
                rsp_next.read_node  = a_rdata[KB-1:1];
                rsp_next.read_value = a_rdata[0];
                rsp_valid_next      = 1'b1;
                state_next          = S_IDLE;
            end

            S_STEP_RD:
            begin
                state_next = S_STEP_EV;
            end

            S_STEP_EV:
            begin
                state_next = S_STEP_RD;
                case (op_reg)
                    saso_pkg::OP_UNION:
                    begin
                        if (!a_more && !b_more)
                        begin
                            walk_done = 1'b1;
                        end
                        else
                        begin
                            // Pick the smaller head; equal keys are kept once.
                            if (!b_more)
                            begin
                                merge_key = a_rdata;
                                i_next    = i_reg + CB'(1);
                            end
                            else if (!a_more)
                            begin
                                merge_key = b_rdata;
                                j_next    = j_reg + CB'(1);
                            end
                            else if (key_lt)
                            begin
                                merge_key = a_rdata;
                                i_next    = i_reg + CB'(1);
                            end
                            else if (!key_eq)
                            begin
                                merge_key = b_rdata;
                                j_next    = j_reg + CB'(1);
                            end
                            else
                            begin
                                merge_key = a_rdata;
                                i_next    = i_reg + CB'(1);
                                j_next    = j_reg + CB'(1);
                            end
                            if (n_reg >= CB'(saso_pkg::DEPTH))
                            begin
                                over_next = 1'b1;
                                walk_done = 1'b1;
                            end
                            else
                            begin
                                s_we    = 1'b1;
                                s_wdata = merge_key;
                                n_next  = n_reg + CB'(1);
                            end
                        end
                    end
                    saso_pkg::OP_DIFF:
                    begin
                        if (!a_more)
                        begin
                            walk_done = 1'b1;
                        end
                        else if (!b_more || key_lt)
                        begin
                            s_we   = 1'b1;
                            n_next = n_reg + CB'(1);
                            i_next = i_reg + CB'(1);
                        end
                        else if (!key_eq)
                        begin
                            j_next = j_reg + CB'(1);
                        end
                        else
                        begin
                            i_next = i_reg + CB'(1);
                            j_next = j_reg + CB'(1);
                        end
                    end
                    saso_pkg::OP_CONFLICT:
                    begin
                        if (!a_more || !b_more)
                        begin
                            chk_done = 1'b1;
                        end
                        else if (node_eq)
                        begin
                            if (!key_eq)
                            begin
                                chk_done    = 1'b1;
                                chk_verdict = 1'b1;
                            end
                            else
                            begin
                                i_next = i_reg + CB'(1);
                                j_next = j_reg + CB'(1);
                            end
                        end
                        else if (key_lt)
                        begin
                            i_next = i_reg + CB'(1);
                        end
                        else
                        begin
                            j_next = j_reg + CB'(1);
                        end
                    end
                    saso_pkg::OP_CONTAIN:
                    begin
                        if (!a_more || !b_more)
                        begin
                            chk_done    = 1'b1;
                            chk_verdict = !b_more;
                        end
                        else if (key_lt)
                        begin
                            i_next = i_reg + CB'(1);
                        end
                        else if (!key_eq)
                        begin
                            chk_done = 1'b1;
                        end
                        else
                        begin
                            i_next = i_reg + CB'(1);
                            j_next = j_reg + CB'(1);
                        end
                    end
                    saso_pkg::OP_SANITY:
                    begin
                        // Neighboring entries of A must not hold one node with two values.
                        if (!a_more)
                        begin
                            chk_done    = 1'b1;
                            chk_verdict = 1'b1;
                        end
                        else if ((i_reg != '0) && node_eq && !key_eq)
                        begin
                            chk_done = 1'b1;
                        end
                        else
                        begin
                            prev_next = a_rdata;
                            i_next    = i_reg + CB'(1);
                        end
                    end
                    default:
                    begin
                        chk_done = 1'b1;
                    end
                endcase

                // A check run ends with its verdict and empties list B.
                if (chk_done)
                begin
                    rsp_next         = '0;
                    rsp_next.count_a = count_a_reg;
                    rsp_next.verdict = chk_verdict;
                    rsp_valid_next   = 1'b1;
                    count_b_next     = '0;
                    state_next       = S_IDLE;
                end

                // Union and difference copy the scratch list back into A.
                if (walk_done)
                begin
                    i_next     = '0;
                    state_next = S_COPY_RD;
                end
            end

            S_COPY_RD:
            begin
                if (i_reg >= n_reg)
                begin
                    count_a_next     = n_reg;
                    count_b_next     = '0;
                    rsp_next         = '0;
                    rsp_next.count_a = n_reg;
                    rsp_next.status  = over_reg ? saso_pkg::ST_FULL : saso_pkg::ST_OK;
                    rsp_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    state_next = S_COPY_WR;
                end
            end

            S_COPY_WR:
            begin
                a_we       = 1'b1;
                i_next     = i_reg + CB'(1);
                state_next = S_COPY_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            op_reg        <= '0;
            over_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            op_reg        <= op_next;
            over_reg      <= over_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ test/saso_result_checker.sv @@
// ============================================================================
// saso_result_checker: result predictor and comparator for the set unit
// Watches both channels, keeps its own copy of lists A and B, predicts one
// result for every input transfer and compares each result transfer with the
// oldest prediction, field by field.
// ============================================================================
module saso_result_checker
    import saso_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   mismatches,
    output int   pending
);

    typedef logic [KEY_BITS-1:0] key_t;

    // Shadow copy of the block's lists and counts.
    key_t list_a [DEPTH];
    key_t list_b [DEPTH];
    key_t merged [DEPTH];
    int   len_a;
    int   len_b;

    // Predicted results, oldest first.
    rsp_t expected_q [$];
    int   result_no;

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic report_mismatch(input string what);
        if (mismatches < 100)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      result_no, field, got, want));
    endtask

    // Merge B into A, equal keys kept once; returns 1 when the merge overflows.
    function automatic logic merge_b_into_a();
        int   i = 0;
        int   j = 0;
        int   n = 0;
        logic over = 1'b0;
        key_t k;
        while (i < len_a || j < len_b)
        begin
            if (j >= len_b)
            begin
                k = list_a[i];
                i++;
            end
            else if (i >= len_a)
            begin
                k = list_b[j];
                j++;
            end
            else if (list_a[i] < list_b[j])
            begin
                k = list_a[i];
                i++;
            end
            else if (list_a[i] > list_b[j])
            begin
                k = list_b[j];
                j++;
            end
            else
            begin
                k = list_a[i];
                i++;
                j++;
            end
            if (n >= DEPTH)
            begin
                over = 1'b1;
                break;
            end
            merged[n] = k;
            n++;
        end
        for (int m = 0; m < n; m++)
            list_a[m] = merged[m];
        len_a = n;
        return over;
    endfunction

    // Drop from A every key that also appears in B.
    function automatic void remove_b_from_a();
        int i = 0;
        int j = 0;
        int n = 0;
        while (i < len_a)
        begin
            if (j >= len_b || list_a[i] < list_b[j])
            begin
                merged[n] = list_a[i];
                n++;
                i++;
            end
            else if (list_a[i] > list_b[j])
            begin
                j++;
            end
            else
            begin
                i++;
                j++;
            end
        end
        for (int m = 0; m < n; m++)
            list_a[m] = merged[m];
        len_a = n;
    endfunction

    // Same node with different values in A and B.
    function automatic logic find_conflict();
        int   i = 0;
        int   j = 0;
        key_t x;
        key_t y;
        while (i < len_a && j < len_b)
        begin
            x = list_a[i];
            y = list_b[j];
            if (x[KEY_BITS-1:1] == y[KEY_BITS-1:1])
            begin
                if (x != y)
                    return 1'b1;
                i++;
                j++;
            end
            else if (x < y)
            begin
                i++;
            end
            else
            begin
                j++;
            end
        end
        return 1'b0;
    endfunction

    // Every key of B is present in A.
    function automatic logic b_within_a();
        int i = 0;
        int j = 0;
        while (i < len_a && j < len_b)
        begin
            if (list_a[i] < list_b[j])
                i++;
            else if (list_a[i] > list_b[j])
                return 1'b0;
            else
            begin
                i++;
                j++;
            end
        end
        return (j < len_b) ? 1'b0 : 1'b1;
    endfunction

    // No two neighbors in A share a node with different values.
    function automatic logic a_consistent();
        for (int i = 1; i < len_a; i++)
        begin
            if (list_a[i-1][KEY_BITS-1:1] == list_a[i][KEY_BITS-1:1]
                && list_a[i-1] != list_a[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one input item to the shadow state and return its result.
    function automatic rsp_t predict_result(input req_t r);
        rsp_t e;
        key_t key;
        e   = '0;
        key = {r.node_id, r.assigned_value};
        case (action_t'(r.action))
            ACT_CLEAR: len_a = 0;
            ACT_APPEND_A:
            begin
                if (len_a < DEPTH)
                begin
                    list_a[len_a] = key;
                    len_a++;
                end
                else
                begin
                    e.status = ST_FULL;
                end
            end
            ACT_APPEND_B:
            begin
                if (len_b < DEPTH)
                begin
                    list_b[len_b] = key;
                    len_b++;
                end
                else
                begin
                    e.status = ST_FULL;
                end
            end
            ACT_RUN:
            begin
                case (op_t'(r.operation))
                    OP_UNION:    if (merge_b_into_a()) e.status = ST_FULL;
                    OP_DIFF:     remove_b_from_a();
                    OP_CONFLICT: e.verdict = find_conflict();
                    OP_CONTAIN:  e.verdict = b_within_a();
                    OP_SANITY:   e.verdict = a_consistent();
                    default:     ;
                endcase
                // Every run empties B, known operation or not.
                len_b = 0;
            end
            ACT_READ:
            begin
                if (int'(r.read_index) < len_a)
                begin
                    e.read_node  = list_a[r.read_index][KEY_BITS-1:1];
                    e.read_value = list_a[r.read_index][0];
                end
                else
                begin
                    e.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        e.count_a = CNT_BITS'(len_a);
        return e;
    endfunction

    // Compare result transfers first, then predict from the input transfer;
    // a result can never belong to an input accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            len_a      = 0;
            len_b      = 0;
            result_no  = 0;
            mismatches = 0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_no));
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("verdict", 32'(rsp.verdict), 32'(want.verdict));
                    check_field("status", 32'(rsp.status), 32'(want.status));
                    check_field("count_a", 32'(rsp.count_a), 32'(want.count_a));
                    check_field("read_node", 32'(rsp.read_node), 32'(want.read_node));
                    check_field("read_value", 32'(rsp.read_value),
                                32'(want.read_value));
                end
                result_no++;
            end
            if (req_valid && !req_stall)
            begin
                want       = predict_result(req);
                expected_q = {expected_q, want};
            end
            pending <= expected_q.size();
        end
    end

endmodule

@@ test/tb_sorted_assignment_set_ops_unit.sv @@
// ============================================================================
// tb_sorted_assignment_set_ops_unit: testbench for the sorted set unit
// Drives directed and random list loads, runs and reads in bursts, stalls the
// result side on a random pattern with one long hold-off, and lets the
// result checker beside the block judge every transfer.
// ============================================================================
module tb_sorted_assignment_set_ops_unit;
    import saso_pkg::*;

    typedef logic [KEY_BITS-1:0] key_t;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int ITEM_TARGET    = 1750;

    // Ways of building list B from list A in a random sequence.
    localparam int B_FRESH  = 0;
    localparam int B_SUBSET = 1;
    localparam int B_SKEWED = 2;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int mismatches;
    int pending;
    int cycles      = 0;
    int sent        = 0;
    int burst_left  = 0;

    sorted_assignment_set_ops_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    saso_result_checker u_result_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("sorted_assignment_set_ops_unit test failed");
        $finish;
    end

    // Result side: one long hold-off early on while items keep coming, then
    // stretches of random stall density, including stretches with none.
    initial
    begin
        int stretch;
        int pct;
        rsp_stall <= 1'b0;
        repeat (30) @(posedge clk);
        rsp_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        forever
        begin
            stretch = $urandom_range(1, 40);
            pct     = $urandom_range(0, 3) * 28;
            repeat (stretch)
            begin
                rsp_stall <= ($urandom_range(0, 99) < pct);
                @(posedge clk);
            end
        end
    end

    // Item with every field random; callers overwrite what matters.
    function automatic req_t noise_item();
        req_t r;
        r.action         = 3'($urandom_range(0, 7));
        r.node_id        = NODE_BITS'($urandom);
        r.assigned_value = 1'($urandom);
        r.operation      = 3'($urandom_range(0, 7));
        r.read_index     = INDEX_BITS'($urandom);
        return r;
    endfunction

    function automatic key_t key_of(input int node, input logic value);
        return {NODE_BITS'(node), value};
    endfunction

    // Start key of a sorted run: mostly anywhere, sometimes at either end.
    function automatic key_t pick_base();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return key_t'((1 << KEY_BITS) - 256);
        else
            return key_t'($urandom_range(0, (1 << KEY_BITS) - 256));
    endfunction

    // Offer one item in bursts with random gaps; return once it is transferred.
    task automatic offer(input req_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        if (item.action <= ACT_READ)
            sent++;
    endtask

    task automatic load_key(input logic [2:0] act, input key_t key);
        req_t r;
        r = noise_item();
        r.action = act;
        {r.node_id, r.assigned_value} = key;
        offer(r);
    endtask

    task automatic clear_a();
        req_t r;
        r = noise_item();
        r.action = ACT_CLEAR;
        offer(r);
    endtask

    task automatic run_op(input logic [2:0] op);
        req_t r;
        r = noise_item();
        r.action    = ACT_RUN;
        r.operation = op;
        offer(r);
    endtask

    task automatic read_a(input logic [INDEX_BITS-1:0] idx);
        req_t r;
        r = noise_item();
        r.action     = ACT_READ;
        r.read_index = idx;
        offer(r);
    endtask

    // A sorted A, a B related to it, one run, then a few reads back.
    task automatic sorted_sequence();
        key_t a_keys [$];
        key_t base;
        key_t k;
        int   na;
        int   shape;
        if ($urandom_range(0, 3) != 0)
            clear_a();
        base = pick_base();
        k    = base;
        na   = $urandom_range(0, 10);
        repeat (na)
        begin
            k      = k + key_t'($urandom_range(0, 4));
            a_keys = {a_keys, k};
            load_key(ACT_APPEND_A, k);
        end
        shape = $urandom_range(B_FRESH, B_SKEWED);
        if (shape == B_FRESH)
        begin
            k = base;
            repeat ($urandom_range(0, 10))
            begin
                k = k + key_t'($urandom_range(1, 4));
                load_key(ACT_APPEND_B, k);
            end
        end
        else
        begin
            foreach (a_keys[i])
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    k = a_keys[i];
                    // A flipped value makes a same-node conflict.
                    if (shape == B_SKEWED && $urandom_range(0, 3) == 0)
                        k[0] = ~k[0];
                    load_key(ACT_APPEND_B, k);
                end
            end
        end
        if ($urandom_range(0, 9) == 0)
            run_op(3'($urandom_range(5, 7)));
        else
            run_op(3'($urandom_range(OP_UNION, OP_SANITY)));
        repeat ($urandom_range(0, 3))
            read_a(INDEX_BITS'($urandom_range(0, na + 1)));
    endtask

    // Near-full lists: appends past the end and a run, often a union that overflows.
    task automatic overflow_sequence();
        key_t base;
        key_t k;
        clear_a();
        base = pick_base();
        k    = base;
        repeat ($urandom_range(60, 66))
        begin
            k = k + key_t'($urandom_range(1, 3));
            load_key(ACT_APPEND_A, k);
        end
        k = base;
        repeat ($urandom_range(20, 66))
        begin
            k = k + key_t'($urandom_range(1, 3));
            load_key(ACT_APPEND_B, k);
        end
        if ($urandom_range(0, 1) == 0)
            run_op(OP_UNION);
        else
            run_op(3'($urandom_range(OP_UNION, OP_SANITY)));
        read_a('1);
        read_a('0);
        read_a(INDEX_BITS'($urandom));
    endtask

    // Stimulus and verdict.
    initial
    begin
        req_t r;
        int   pick;
        req_valid <= 1'b0;
        req       <= '0;
        rst_n     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty lists, extreme nodes, each operation and odd codes.
        read_a('0);
        run_op(OP_SANITY);
        run_op(OP_CONTAIN);
        load_key(ACT_APPEND_A, key_of(0, 1'b0));
        load_key(ACT_APPEND_A, {{NODE_BITS{1'b1}}, 1'b1});
        read_a('0);
        read_a(INDEX_BITS'(1));
        read_a('1);
        load_key(ACT_APPEND_B, {{NODE_BITS{1'b1}}, 1'b0});
        run_op(OP_CONFLICT);
        load_key(ACT_APPEND_B, key_of(0, 1'b0));
        run_op(OP_CONTAIN);
        clear_a();
        load_key(ACT_APPEND_A, key_of(5, 1'b0));
        load_key(ACT_APPEND_A, key_of(5, 1'b1));
        run_op(OP_SANITY);
        load_key(ACT_APPEND_B, key_of(5, 1'b1));
        run_op(OP_DIFF);
        load_key(ACT_APPEND_B, key_of(3, 1'b1));
        load_key(ACT_APPEND_B, key_of(7, 1'b0));
        run_op(OP_UNION);
        read_a(INDEX_BITS'(2));
        load_key(ACT_APPEND_B, key_of(9, 1'b0));
        run_op(3'($urandom_range(5, 7)));
        run_op(OP_CONTAIN);
        r = noise_item();
        r.action = 3'($urandom_range(5, 7));
        offer(r);

        // Random: mostly well-formed sequences, some overflow runs and noise.
        while (sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                overflow_sequence();
            else if (pick < 15)
                repeat ($urandom_range(1, 8)) offer(noise_item());
            else
                sorted_sequence();
        end
        req_valid <= 1'b0;

        // Let the checker count the last input transfer before waiting.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("sorted_assignment_set_ops_unit test passed");
        else
            $display("sorted_assignment_set_ops_unit test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/saso_pkg.sv
rtl/saso_ram.sv
rtl/sorted_assignment_set_ops_unit.sv
test/saso_result_checker.sv
test/tb_sorted_assignment_set_ops_unit.sv
